// ===== hdl/lqgc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lqgc_pkg
// Types, constants, saturation helpers and the microcode table of the
// LQG controller with integral action.
// ----------------------------------------------------------------------------
package lqgc_pkg;

    localparam int PC_W   = 5;
    localparam int CIDX_W = 3;

    localparam logic [CIDX_W-1:0] CFG_A   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_B   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_K0  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_KI  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_F   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_LIM = 3'd5;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_LAST,
        SEQ_JUMP0
    } seq_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LDA,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_PSH,
        OP_PACC,
        OP_CLIP
    } op_t;

    typedef enum logic [3:0] {
        SRC_SP,
        SRC_MEAS,
        SRC_A,
        SRC_B,
        SRC_K0,
        SRC_KI,
        SRC_F,
        SRC_EST,
        SRC_INT,
        SRC_T0,
        SRC_T1,
        SRC_T2,
        SRC_DRV
    } src_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_T0,
        DST_T1,
        DST_T2,
        DST_DRV,
        DST_EST,
        DST_INT
    } dst_t;

    typedef struct packed {
        seq_t seq;
        op_t  op;
        src_t sx;
        src_t sy;
        dst_t dst;
    } uword_t;

    typedef struct packed {
        uword_t uw;
        logic   ld_in;
        logic   emit;
    } ctl_t;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        if (v > 48'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -48'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic uword_t mk(input seq_t s, input op_t o, input src_t x,
                                  input src_t y, input dst_t d);
        uword_t w;
        w.seq = s;
        w.op  = o;
        w.sx  = x;
        w.sy  = y;
        w.dst = d;
        return w;
    endfunction

    // Destination takes sat(acc) of the step's start; op then updates acc.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:    w = mk(SEQ_WAIT_IN, OP_NOP,  SRC_SP,   SRC_SP,  DST_NONE);
            5'd1:    w = mk(SEQ_NEXT,    OP_LDA,  SRC_SP,   SRC_SP,  DST_NONE);
            5'd2:    w = mk(SEQ_NEXT,    OP_SUB,  SRC_MEAS, SRC_SP,  DST_NONE);
            5'd3:    w = mk(SEQ_NEXT,    OP_NOP,  SRC_SP,   SRC_SP,  DST_T0);   // error
            5'd4:    w = mk(SEQ_NEXT,    OP_MUL,  SRC_KI,   SRC_T0,  DST_NONE);
            5'd5:    w = mk(SEQ_NEXT,    OP_PSH,  SRC_SP,   SRC_SP,  DST_NONE);
            5'd6:    w = mk(SEQ_NEXT,    OP_ADD,  SRC_INT,  SRC_SP,  DST_NONE);
            5'd7:    w = mk(SEQ_NEXT,    OP_MUL,  SRC_K0,   SRC_EST, DST_T1);   // int_new
            5'd8:    w = mk(SEQ_NEXT,    OP_PSH,  SRC_SP,   SRC_SP,  DST_NONE);
            5'd9:    w = mk(SEQ_NEXT,    OP_LDA,  SRC_INT,  SRC_SP,  DST_T2);   // k0*est
            5'd10:   w = mk(SEQ_NEXT,    OP_SUB,  SRC_T2,   SRC_SP,  DST_NONE);
            5'd11:   w = mk(SEQ_NEXT,    OP_CLIP, SRC_SP,   SRC_SP,  DST_T2);   // raw
            5'd12:   w = mk(SEQ_NEXT,    OP_LDA,  SRC_T1,   SRC_SP,  DST_DRV);  // drive
            5'd13:   w = mk(SEQ_NEXT,    OP_SUB,  SRC_T2,   SRC_SP,  DST_NONE);
            5'd14:   w = mk(SEQ_NEXT,    OP_ADD,  SRC_DRV,  SRC_SP,  DST_NONE);
            5'd15:   w = mk(SEQ_NEXT,    OP_LDA,  SRC_MEAS, SRC_SP,  DST_INT);
            5'd16:   w = mk(SEQ_NEXT,    OP_SUB,  SRC_EST,  SRC_SP,  DST_NONE);
            5'd17:   w = mk(SEQ_NEXT,    OP_MUL,  SRC_A,    SRC_EST, DST_T0);   // est_err
            5'd18:   w = mk(SEQ_NEXT,    OP_PSH,  SRC_SP,   SRC_SP,  DST_NONE);
            5'd19:   w = mk(SEQ_NEXT,    OP_MUL,  SRC_B,    SRC_DRV, DST_NONE);
            5'd20:   w = mk(SEQ_NEXT,    OP_PACC, SRC_SP,   SRC_SP,  DST_NONE);
            5'd21:   w = mk(SEQ_NEXT,    OP_MUL,  SRC_F,    SRC_T0,  DST_NONE);
            5'd22:   w = mk(SEQ_NEXT,    OP_PACC, SRC_SP,   SRC_SP,  DST_NONE);
            5'd23:   w = mk(SEQ_LAST,    OP_NOP,  SRC_SP,   SRC_SP,  DST_EST);
            default: w = mk(SEQ_JUMP0,   OP_NOP,  SRC_SP,   SRC_SP,  DST_NONE);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/lqg_integral_antiwindup_controller_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lqg_integral_antiwindup_controller_top
// Single-state LQG velocity controller, Q16.16, with integral action and
// back-calculation anti-windup, run by a 24-step microprogram.
// A new input item is accepted only after the previous one has run through
// the whole microprogram on the single shared multiplier and accumulator,
// and later while a finished drive item waits for out_ready.
// Reset clears gains, limit, state estimate and integral term.
// ----------------------------------------------------------------------------
module lqg_integral_antiwindup_controller_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [31:0]          setpoint,
    input  wire logic signed [31:0]          measured,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [31:0]               drive,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lqgc_pkg::CIDX_W-1:0] cfg_addr,
    input  wire logic [31:0]                 cfg_wdata
);

    lqgc_pkg::ctl_t ctl;

    lqgc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    lqgc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .setpoint  (setpoint),
        .measured  (measured),
        .drive     (drive)
    );

endmodule
`default_nettype wire

// ===== hdl/lqgc_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lqgc_seq
// Step counter and microcode fetch; handles the input and output handshakes.
// ----------------------------------------------------------------------------
module lqgc_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output lqgc_pkg::ctl_t      ctl
);

    logic [lqgc_pkg::PC_W-1:0] pc_reg;
    logic [lqgc_pkg::PC_W-1:0] pc_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    lqgc_pkg::uword_t          uw;
    logic                      blocked;
    logic                      emit;

    assign uw       = lqgc_pkg::ucode(pc_reg);
    assign in_ready = (uw.seq == lqgc_pkg::SEQ_WAIT_IN);
    assign blocked  = out_valid_reg && !out_ready;
    assign emit     = (uw.seq == lqgc_pkg::SEQ_LAST) && !blocked;

    always_comb
    begin
        pc_next = pc_reg;
        case (uw.seq)
            lqgc_pkg::SEQ_WAIT_IN:
            begin
                if (in_valid)
                    pc_next = pc_reg + 1'b1;
            end
            lqgc_pkg::SEQ_NEXT:
                pc_next = pc_reg + 1'b1;
            lqgc_pkg::SEQ_LAST:
            begin
                if (!blocked)
                    pc_next = '0;
            end
            lqgc_pkg::SEQ_JUMP0:
                pc_next = '0;
            default:
                pc_next = '0;
        endcase
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ctl.uw    = uw;
    assign ctl.ld_in = in_ready && in_valid;
    assign ctl.emit  = emit;

endmodule
`default_nettype wire

// ===== hdl/lqgc_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lqgc_dp
// Datapath: gain registers, state, temporaries, one shared 32x32 multiplier
// and a 34-bit saturating accumulator.
// ----------------------------------------------------------------------------
module lqgc_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lqgc_pkg::ctl_t                    ctl,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lqgc_pkg::CIDX_W-1:0]       cfg_addr,
    input  wire logic [31:0]                       cfg_wdata,
    input  wire logic signed [31:0]                setpoint,
    input  wire logic signed [31:0]                measured,
    output logic signed [31:0]                     drive
);

    logic signed [31:0] a_reg, b_reg, k0_reg, ki_reg, f_reg;
    logic        [30:0] lim_reg;
    logic signed [31:0] est_reg, int_reg;
    logic signed [31:0] sp_reg, meas_reg;
    logic signed [31:0] t0_reg, t1_reg, t2_reg, drv_reg;
    logic signed [31:0] out_reg;
    logic signed [63:0] prod_reg;
    logic signed [33:0] acc_reg;
    logic signed [33:0] acc_next;
    logic signed [31:0] opx;
    logic signed [31:0] opy;
    logic signed [31:0] acc_sat;
    logic signed [31:0] psh;
    logic signed [33:0] lim_pos;

    function automatic logic signed [31:0] pick(
        input lqgc_pkg::src_t s,
        input logic signed [31:0] sp, input logic signed [31:0] me,
        input logic signed [31:0] ga, input logic signed [31:0] gb,
        input logic signed [31:0] gk0, input logic signed [31:0] gki,
        input logic signed [31:0] gf, input logic signed [31:0] es,
        input logic signed [31:0] it, input logic signed [31:0] x0,
        input logic signed [31:0] x1, input logic signed [31:0] x2,
        input logic signed [31:0] dr);
        logic signed [31:0] r;
        case (s)
            lqgc_pkg::SRC_SP:   r = sp;
            lqgc_pkg::SRC_MEAS: r = me;
            lqgc_pkg::SRC_A:    r = ga;
            lqgc_pkg::SRC_B:    r = gb;
            lqgc_pkg::SRC_K0:   r = gk0;
            lqgc_pkg::SRC_KI:   r = gki;
            lqgc_pkg::SRC_F:    r = gf;
            lqgc_pkg::SRC_EST:  r = es;
            lqgc_pkg::SRC_INT:  r = it;
            lqgc_pkg::SRC_T0:   r = x0;
            lqgc_pkg::SRC_T1:   r = x1;
            lqgc_pkg::SRC_T2:   r = x2;
            lqgc_pkg::SRC_DRV:  r = dr;
            default:            r = '0;
        endcase
        return r;
    endfunction

    assign opx = pick(ctl.uw.sx, sp_reg, meas_reg, a_reg, b_reg, k0_reg, ki_reg, f_reg,
                      est_reg, int_reg, t0_reg, t1_reg, t2_reg, drv_reg);
    assign opy = pick(ctl.uw.sy, sp_reg, meas_reg, a_reg, b_reg, k0_reg, ki_reg, f_reg,
                      est_reg, int_reg, t0_reg, t1_reg, t2_reg, drv_reg);

    assign acc_sat = lqgc_pkg::sat34(acc_reg);
    // floor shift by 16 is the arithmetic shift of the exact product
    assign psh     = lqgc_pkg::sat48(prod_reg[63:16]);
    assign lim_pos = {3'b000, lim_reg};

    always_comb
    begin
        acc_next = acc_reg;
        case (ctl.uw.op)
            lqgc_pkg::OP_NOP:  acc_next = acc_reg;
            lqgc_pkg::OP_LDA:  acc_next = 34'(opx);
            lqgc_pkg::OP_ADD:  acc_next = acc_reg + 34'(opx);
            lqgc_pkg::OP_SUB:  acc_next = acc_reg - 34'(opx);
            lqgc_pkg::OP_MUL:  acc_next = acc_reg;
            lqgc_pkg::OP_PSH:  acc_next = 34'(psh);
            lqgc_pkg::OP_PACC: acc_next = acc_reg + 34'(psh);
            lqgc_pkg::OP_CLIP:
            begin
                if (acc_reg > lim_pos)
                    acc_next = lim_pos;
                else if (acc_reg < -lim_pos)
                    acc_next = -lim_pos;
                else
                    acc_next = acc_reg;
            end
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctl.uw.op == lqgc_pkg::OP_MUL)
            prod_reg <= opx * opy;
        if (ctl.ld_in)
        begin
            sp_reg   <= setpoint;
            meas_reg <= measured;
        end
        case (ctl.uw.dst)
            lqgc_pkg::DST_T0:  t0_reg  <= acc_sat;
            lqgc_pkg::DST_T1:  t1_reg  <= acc_sat;
            lqgc_pkg::DST_T2:  t2_reg  <= acc_sat;
            lqgc_pkg::DST_DRV: drv_reg <= acc_sat;
            default:           ;
        endcase
        if (ctl.emit)
            out_reg <= drv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= '0;
            int_reg <= '0;
        end
        else
        begin
            if (ctl.uw.dst == lqgc_pkg::DST_EST)
                est_reg <= acc_sat;
            if (ctl.uw.dst == lqgc_pkg::DST_INT)
                int_reg <= acc_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            b_reg   <= '0;
            k0_reg  <= '0;
            ki_reg  <= '0;
            f_reg   <= '0;
            lim_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                lqgc_pkg::CFG_A:   a_reg   <= cfg_wdata;
                lqgc_pkg::CFG_B:   b_reg   <= cfg_wdata;
                lqgc_pkg::CFG_K0:  k0_reg  <= cfg_wdata;
                lqgc_pkg::CFG_KI:  ki_reg  <= cfg_wdata;
                lqgc_pkg::CFG_F:   f_reg   <= cfg_wdata;
                lqgc_pkg::CFG_LIM: lim_reg <= cfg_wdata[30:0];
                default:           ;
            endcase
        end
    end

    assign drive = out_reg;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - LQG integral anti-windup controller testbench
// Drives setpoint/measured items through the valid/ready input channel and
// checks every drive item against a bit-exact Q16.16 model of the controller
// (observer, clipped drive, back-calculated integral) kept in a scoreboard.
// Gains are reloaded between bursts, including extreme and zero-limit
// settings, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int BURSTS       = 8;
    localparam int BURST_ITEMS  = 170;

    localparam logic [lqgc_pkg::CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [lqgc_pkg::CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [31:0] Q_MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MINV = 32'h8000_0000;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_MONE = 32'hFFFF_0000;

    class drive_scoreboard;
        longint gain_a, gain_b, gain_k0, gain_ki, gain_f, lim;
        longint est, integ;
        logic [31:0] drive_q[$];
        int errors;
        int checked;

        function new();
            gain_a  = 0;
            gain_b  = 0;
            gain_k0 = 0;
            gain_ki = 0;
            gain_f  = 0;
            lim     = 0;
            est     = 0;
            integ   = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // Q16.16 product, floor shift, saturate
        function longint qmul(longint x, longint y);
            longint p;
            p = x * y;
            return clamp32(p >>> 16);
        endfunction

        function void set_reg(logic [lqgc_pkg::CIDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                lqgc_pkg::CFG_A:   gain_a  = longint'($signed(val));
                lqgc_pkg::CFG_B:   gain_b  = longint'($signed(val));
                lqgc_pkg::CFG_K0:  gain_k0 = longint'($signed(val));
                lqgc_pkg::CFG_KI:  gain_ki = longint'($signed(val));
                lqgc_pkg::CFG_F:   gain_f  = longint'($signed(val));
                lqgc_pkg::CFG_LIM: lim     = longint'({33'd0, val[30:0]});
                default: ;
            endcase
        endfunction

        function void note_input(logic [31:0] sp, logic [31:0] ms);
            longint s, m, err, int_new, raw, drv, est_err;
            s = longint'($signed(sp));
            m = longint'($signed(ms));
            err = clamp32(s - m);
            int_new = clamp32(integ + qmul(gain_ki, err));
            raw = clamp32(integ - qmul(gain_k0, est));
            drv = raw;
            if (drv < -lim)
                drv = -lim;
            else if (drv > lim)
                drv = lim;
            integ = clamp32(int_new - (raw - drv));
            est_err = clamp32(m - est);
            est = clamp32(qmul(gain_a, est) + qmul(gain_b, drv) + qmul(gain_f, est_err));
            drive_q.push_back(drv[31:0]);
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (drive_q.size() == 0)
            begin
                $display("%0t: drive item with none expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            checked++;
            if (got !== want)
            begin
                $display("%0t: drive mismatch, expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [31:0]            setpoint;
    logic signed [31:0]            measured;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [31:0]            drive;
    logic                          cfg_wr_en;
    logic [lqgc_pkg::CIDX_W-1:0]   cfg_addr;
    logic [31:0]                   cfg_wdata;

    drive_scoreboard sb;
    int idle_pct;
    int hold_requests;
    int holds_served;
    int stall_cycles;
    int items_sent;
    int settings_loaded;

    lqg_integral_antiwindup_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .setpoint  (setpoint),
        .measured  (measured),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(4))
            0:       return Q_MAXV;
            1:       return Q_MINV;
            2:       return 32'd0;
            3:       return Q_ONE;
            default: return Q_MONE;
        endcase
    endfunction

    // mostly modest values so the loop stays out of saturation
    function automatic logic [31:0] rand_sample();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 32'($urandom_range(32'h0020_0000) - 32'h0010_0000);
        else if (r < 90)
            return $urandom;
        return pick_extreme();
    endfunction

    function automatic logic [31:0] rand_gain();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 32'($urandom_range(32'h0004_0000) - 32'h0002_0000);
        else if (r < 90)
            return $urandom;
        return pick_extreme();
    endfunction

    function automatic logic [31:0] rand_limit();
        int r;
        logic [31:0] v;
        r = $urandom_range(99);
        if (r < 70)
            v = $urandom_range(32'h0014_0000);
        else if (r < 90)
            v = $urandom;
        else
            v = 32'd0;
        v[31] = 1'($urandom_range(1));
        return v;
    endfunction

    task automatic write_reg(input logic [lqgc_pkg::CIDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_regs(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] k0, input logic [31:0] ki,
                             input logic [31:0] f, input logic [31:0] lim);
        write_reg(lqgc_pkg::CFG_A, a);
        write_reg(lqgc_pkg::CFG_B, b);
        write_reg(lqgc_pkg::CFG_K0, k0);
        write_reg(lqgc_pkg::CFG_KI, ki);
        write_reg(lqgc_pkg::CFG_F, f);
        write_reg(lqgc_pkg::CFG_LIM, lim);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        settings_loaded++;
    endtask

    task automatic send_item(input logic [31:0] sp, input logic [31:0] ms);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        setpoint <= sp;
        measured <= ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(sp, ms);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // output side: random back-pressure, plus one long hold on request
    initial
    begin
        out_ready <= 1'b0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(drive);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] dir_sp[20];
        logic [31:0] dir_ms[20];
        int i;
        int ph;

        sb = new();
        idle_pct = 16;
        hold_requests = 0;
        stall_cycles = 0;
        items_sent = 0;
        settings_loaded = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        setpoint  <= '0;
        measured  <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;

        dir_sp = '{Q_MAXV, 32'd0,
                   32'h0005_0000, 32'h0005_0000, Q_MAXV, Q_MAXV, Q_MINV, 32'd0,
                   Q_MONE, Q_MINV,
                   32'h0003_0000, Q_MAXV, 32'd0, Q_MINV,
                   Q_MAXV, Q_MINV, Q_MAXV, 32'h1234_5678, 32'd0, 32'hFFFF_FFFF};
        dir_ms = '{Q_MINV, 32'd0,
                   32'd0, Q_ONE, Q_MINV, Q_MINV, Q_MAXV, 32'd0,
                   32'h0002_0000, Q_MINV,
                   32'd0, 32'd0, Q_MAXV, 32'd0,
                   Q_MINV, Q_MAXV, Q_MAXV, 32'hEDCB_A987, 32'd0, 32'd1};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: drive must stay at zero
        for (i = 0; i < 2; i++)
            send_item(dir_sp[i], dir_ms[i]);
        settle();

        load_regs(32'h0000_8000, 32'h0000_4000, Q_MONE, Q_ONE, 32'h0000_8000,
                  32'h000A_0000);
        for (i = 2; i < 10; i++)
            send_item(dir_sp[i], dir_ms[i]);
        settle();

        // zero limit, written with the unused top bit set
        load_regs(32'h0000_8000, 32'h0000_4000, Q_MONE, Q_ONE, 32'h0000_8000, Q_MINV);
        for (i = 10; i < 14; i++)
            send_item(dir_sp[i], dir_ms[i]);
        settle();

        load_regs(Q_MAXV, Q_MINV, Q_MINV, Q_MAXV, Q_MAXV, 32'hFFFF_FFFF);
        for (i = 14; i < 20; i++)
            send_item(dir_sp[i], dir_ms[i]);
        settle();

        for (ph = 0; ph < BURSTS; ph++)
        begin
            idle_pct = (ph == 1) ? 0 : 16;
            if (ph == 6)
                load_regs(Q_MINV, Q_MAXV, Q_MAXV, Q_MINV, Q_MINV, Q_MAXV);
            else if (ph == 7)
                load_regs(pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme(), 32'd0);
            else
                load_regs(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                          rand_gain(), rand_limit());
            for (i = 0; i < BURST_ITEMS; i++)
            begin
                if (ph == 2 && i == 40)
                    hold_requests++;
                send_item(rand_sample(), rand_sample());
            end
            settle();
        end

        if (sb.pending() != 0)
        begin
            $display("%0t: %0d drive items never arrived", $time, sb.pending());
            sb.errors += sb.pending();
        end

        $display("Sent %0d items across %0d gain settings (extremes, zero limit, long stall).",
                 items_sent, settings_loaded);
        $display("Checked %0d drive items, %0d errors.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
